>>> src/iso_tri_pkg.sv
`timescale 1ns / 1ps

package iso_tri_pkg;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;

  localparam int TRI_FULL_WIDTH = 16;
  localparam int TRI_HALF_ROWS  = 8;
  localparam int TRI_STEP       = 2;
  localparam int TRI_LAST_ROW   = 14;

  localparam int ADDR_W  = 17;
  localparam int COORD_W = 17;
  localparam int CFG_W   = 8;

  typedef enum logic [1:0] {
    MODE_TEX_SHADE = 2'd0,
    MODE_SKY       = 2'd1,
    MODE_TRANSP    = 2'd2
  } mode_t;

  typedef enum logic [0:0] {
    CFG_TARGET_OVERLAY = 1'b0,
    CFG_SKY_COLOR      = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              start_req;
    logic              side;
    logic [1:0]        mode;
    logic signed [15:0] apex_x;
    logic signed [15:0] origin_y;
    logic [7:0]        color_flags;
    logic [7:0]        texel;
    logic [7:0]        shadow_bits;
    logic [7:0]        water_bits;
  } in_item_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        pixel_color;
    logic              to_overlay;
    logic              triangle_done;
  } out_item_t;

  // Pixel after walking: position not yet checked against the screen.
  typedef struct packed {
    logic               we;
    logic [7:0]         color;
    logic               ovl;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               done;
  } pix_t;

  function automatic logic [4:0] row_width(input logic [3:0] r);
    logic [4:0] w;
    if (r < 4'(TRI_HALF_ROWS)) begin
      w = 5'(TRI_STEP) * (5'(r) + 5'd1);
    end else begin
      w = 5'(TRI_FULL_WIDTH) - 5'(TRI_STEP) * (5'(r) - 5'(TRI_HALF_ROWS - 1));
    end
    return w;
  endfunction

endpackage

>>> src/iso_tri_blitter_top.sv
`timescale 1ns / 1ps

// Isometric half-triangle blitter. Takes one texel transaction per clock and
// returns one frame-buffer write transaction per texel of an active triangle.
// Its first register holds the walked pixel (position
// counters, color composition), the second the screen-clipped write with
// its address from one y*SCREEN_WIDTH multiply-add. A start transaction
// latches origin, side, mode and flags and is itself pixel 0; after the
// 128th pixel (triangle_done) transactions without start are dropped with no
// result. Rate is one transaction per clock, limited only by out_stall.
// Write configuration only while no transactions are in flight.
module iso_triangle_blitter_top #(
  parameter int SCREEN_WIDTH  = iso_tri_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = iso_tri_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  iso_tri_pkg::in_item_t           in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output iso_tri_pkg::out_item_t          out_data,
  input  logic                            cfg_we,
  input  iso_tri_pkg::cfg_idx_t           cfg_index,
  input  logic [iso_tri_pkg::CFG_W-1:0]   cfg_data
);

  logic                   target_overlay_r;
  logic [7:0]             sky_color_r;

  logic                   advance;
  logic                   accept;
  logic                   pix_valid;
  iso_tri_pkg::pix_t      pix_nxt;
  logic                   s1_valid_r;
  iso_tri_pkg::pix_t      s1_r;
  iso_tri_pkg::out_item_t res_nxt;
  logic                   out_valid_r;
  iso_tri_pkg::out_item_t out_r;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_overlay_r <= 1'b0;
      sky_color_r      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        iso_tri_pkg::CFG_TARGET_OVERLAY: target_overlay_r <= cfg_data[0];
        iso_tri_pkg::CFG_SKY_COLOR:      sky_color_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  iso_tri_walker u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_item        (in_data),
    .target_overlay (target_overlay_r),
    .sky_color      (sky_color_r),
    .pix_valid      (pix_valid),
    .pix            (pix_nxt)
  );

  iso_tri_compose #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_compose (
    .pix    (s1_r),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= pix_valid;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= pix_nxt;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_unwritten_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.write_enable) |->
      (out_r.pixel_color == 8'd0 && !out_r.to_overlay && out_r.pixel_address == '0))
    else $error("unwritten pixel carries nonzero fields");

  a_s1_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_stall && !in_valid) |=> out_valid_r)
    else $error("walked pixel lost between stages");

endmodule

>>> src/iso_tri_walker.sv
`timescale 1ns / 1ps

module iso_tri_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  iso_tri_pkg::in_item_t in_item,
  input  logic                 target_overlay,
  input  logic [7:0]           sky_color,
  output logic                 pix_valid,
  output iso_tri_pkg::pix_t    pix
);

  logic        active_r, active_nxt;
  logic [3:0]  row_r, row_nxt;
  logic [3:0]  col_r, col_nxt;
  logic [15:0] base_x_r, base_x_nxt;
  logic [15:0] base_y_r, base_y_nxt;
  logic        side_r, side_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [7:0]  flags_r, flags_nxt;

  logic [4:0]  width;
  logic        row_end;
  logic        last_row;
  logic [iso_tri_pkg::COORD_W-1:0] bx, by;

  always_comb begin
    // a start transaction takes effect for its own texel
    active_nxt = active_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    base_x_nxt = base_x_r;
    base_y_nxt = base_y_r;
    side_nxt   = side_r;
    mode_nxt   = mode_r;
    flags_nxt  = flags_r;
    if (in_item.start_req) begin
      active_nxt = 1'b1;
      row_nxt    = 4'd0;
      col_nxt    = 4'd0;
      base_x_nxt = in_item.apex_x;
      base_y_nxt = in_item.origin_y;
      side_nxt   = in_item.side;
      mode_nxt   = in_item.mode;
      flags_nxt  = in_item.color_flags;
    end

    pix_valid = active_nxt;
    width     = iso_tri_pkg::row_width(row_nxt);
    row_end   = (5'(col_nxt) + 5'd1) >= width;
    last_row  = row_nxt >= 4'(iso_tri_pkg::TRI_LAST_ROW);

    bx = {base_x_nxt[15], base_x_nxt};
    by = {base_y_nxt[15], base_y_nxt};
    if (side_nxt) begin
      pix.x = bx + iso_tri_pkg::COORD_W'(col_nxt);
    end else begin
      pix.x = bx - iso_tri_pkg::COORD_W'(width) + iso_tri_pkg::COORD_W'(col_nxt);
    end
    pix.y    = by + iso_tri_pkg::COORD_W'(row_nxt);
    pix.done = row_end && last_row;

    case (mode_nxt)
      iso_tri_pkg::MODE_TEX_SHADE: begin
        pix.we    = 1'b1;
        pix.color = in_item.texel | in_item.shadow_bits | in_item.water_bits;
        pix.ovl   = target_overlay;
      end
      iso_tri_pkg::MODE_SKY: begin
        pix.we    = 1'b1;
        pix.color = sky_color | in_item.water_bits;
        pix.ovl   = target_overlay;
      end
      iso_tri_pkg::MODE_TRANSP: begin
        pix.we    = in_item.texel != 8'd0;
        pix.color = in_item.texel | flags_nxt;
        pix.ovl   = 1'b0;
      end
      default: begin
        pix.we    = 1'b0;
        pix.color = 8'd0;
        pix.ovl   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= 4'd0;
      col_r    <= 4'd0;
      base_x_r <= 16'd0;
      base_y_r <= 16'd0;
      side_r   <= 1'b0;
      mode_r   <= 2'd0;
      flags_r  <= 8'd0;
    end else if (accept) begin
      base_x_r <= base_x_nxt;
      base_y_r <= base_y_nxt;
      side_r   <= side_nxt;
      mode_r   <= mode_nxt;
      flags_r  <= flags_nxt;
      if (active_nxt) begin
        if (row_end) begin
          col_r <= 4'd0;
          if (last_row) begin
            active_r <= 1'b0;
            row_r    <= 4'd0;
          end else begin
            active_r <= 1'b1;
            row_r    <= row_nxt + 4'd1;
          end
        end else begin
          active_r <= 1'b1;
          row_r    <= row_nxt;
          col_r    <= col_nxt + 4'd1;
        end
      end
    end
  end

endmodule

>>> src/iso_tri_compose.sv
`timescale 1ns / 1ps

module iso_tri_compose #(
  parameter int SCREEN_WIDTH  = iso_tri_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = iso_tri_pkg::DEF_SCREEN_HEIGHT
) (
  input  iso_tri_pkg::pix_t      pix,
  output iso_tri_pkg::out_item_t result
);

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam int AW = XW + YW;
  localparam int CW = iso_tri_pkg::COORD_W;

  logic          on_screen;
  logic [AW-1:0] lin_addr;

  always_comb begin
    on_screen = !pix.x[CW-1] && (pix.x < CW'(SCREEN_WIDTH)) &&
                !pix.y[CW-1] && (pix.y < CW'(SCREEN_HEIGHT));
    lin_addr  = AW'(pix.y[YW-1:0]) * AW'(SCREEN_WIDTH) + AW'(pix.x[XW-1:0]);

    result.write_enable  = pix.we && on_screen;
    result.triangle_done = pix.done;
    if (result.write_enable) begin
      result.pixel_address = iso_tri_pkg::ADDR_W'(lin_addr);
      result.pixel_color   = pix.color;
      result.to_overlay    = pix.ovl;
    end else begin
      result.pixel_address = '0;
      result.pixel_color   = 8'd0;
      result.to_overlay    = 1'b0;
    end
  end

endmodule

>>> tb/sv/iso_triangle_blitter_top_tb.sv
`timescale 1ns / 1ps

module iso_triangle_blitter_top_tb;
  import iso_tri_pkg::*;

  localparam int SCR_W         = DEF_SCREEN_WIDTH;
  localparam int SCR_H         = DEF_SCREEN_HEIGHT;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 350;
  localparam int PHASE_ITEMS   = 225;
  localparam int NUM_PHASES    = 5;
  localparam int MAX_PRINTED   = 60;

  // mode code the block leaves unused
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  cfg_idx_t         cfg_index = CFG_TARGET_OVERLAY;
  logic [CFG_W-1:0] cfg_data  = '0;

  iso_triangle_blitter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the blitter: configuration and triangle walk state.
  logic               shd_overlay = 1'b0;
  logic [7:0]         shd_sky     = '0;
  logic               tri_active  = 1'b0;
  logic [3:0]         tri_row     = '0;
  logic [3:0]         tri_col     = '0;
  logic signed [15:0] tri_bx      = '0;
  logic signed [15:0] tri_by      = '0;
  logic               tri_side    = 1'b0;
  logic [1:0]         tri_mode    = '0;
  logic [7:0]         tri_flags   = '0;

  in_item_t  texel_queue[$];
  out_item_t pixel_writes_due[$];

  int err_count    = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int send_gap     = 0;
  int send_calm    = 0;
  int recv_calm    = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  out_item_t drv_pix;
  bit        drv_has;

  // Walks one texel through the triangle; returns 0 when the texel is dropped.
  function automatic bit blit_texel(input in_item_t it, output out_item_t pix);
    int         w;
    int         x;
    int         y;
    logic       we;
    logic [7:0] color;
    logic       ovl;
    pix = '0;
    if (it.start_req) begin
      tri_active = 1'b1;
      tri_row    = '0;
      tri_col    = '0;
      tri_side   = it.side;
      tri_mode   = it.mode;
      tri_bx     = it.apex_x;
      tri_by     = it.origin_y;
      tri_flags  = it.color_flags;
    end
    if (!tri_active) return 1'b0;

    if (tri_row < 4'(TRI_HALF_ROWS))
      w = TRI_STEP * (int'(tri_row) + 1);
    else
      w = TRI_FULL_WIDTH - TRI_STEP * (int'(tri_row) - (TRI_HALF_ROWS - 1));
    x = tri_side ? int'(tri_bx) + int'(tri_col) : int'(tri_bx) - w + int'(tri_col);
    y = int'(tri_by) + int'(tri_row);

    case (tri_mode)
      MODE_TEX_SHADE: begin
        we    = 1'b1;
        color = it.texel | it.shadow_bits | it.water_bits;
        ovl   = shd_overlay;
      end
      MODE_SKY: begin
        we    = 1'b1;
        color = shd_sky | it.water_bits;
        ovl   = shd_overlay;
      end
      MODE_TRANSP: begin
        we    = (it.texel != 8'd0);
        color = it.texel | tri_flags;
        ovl   = 1'b0;
      end
      default: begin
        we    = 1'b0;
        color = '0;
        ovl   = 1'b0;
      end
    endcase
    if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) we = 1'b0;

    pix.write_enable = we;
    if (we) begin
      pix.pixel_address = ADDR_W'(y * SCR_W + x);
      pix.pixel_color   = color;
      pix.to_overlay    = ovl;
    end

    if (int'(tri_col) + 1 >= w) begin
      tri_col = '0;
      if (tri_row >= 4'(TRI_LAST_ROW)) begin
        pix.triangle_done = 1'b1;
        tri_active        = 1'b0;
        tri_row           = '0;
      end else begin
        tri_row = tri_row + 4'd1;
      end
    end else begin
      tri_col = tri_col + 4'd1;
    end
    return 1'b1;
  endfunction

  // Idle length for either side: mostly short, a few long, with calm stretches.
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t mk_item(input logic st, input logic sd, input logic [1:0] md,
                                       input logic signed [15:0] ox,
                                       input logic signed [15:0] oy, input logic [7:0] fl,
                                       input logic [7:0] tx, input logic [7:0] sh,
                                       input logic [7:0] wa);
    in_item_t it;
    it.start_req   = st;
    it.side        = sd;
    it.mode        = md;
    it.apex_x      = ox;
    it.origin_y    = oy;
    it.color_flags = fl;
    it.texel       = tx;
    it.shadow_bits = sh;
    it.water_bits  = wa;
    return it;
  endfunction

  function automatic logic signed [15:0] pick_coord(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'(int'($urandom_range(0, span + 40)) - 20);
    if (r < 85) return 16'($urandom);
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sd0;
      3:       return -16'sd1;
      4:       return 16'(span - 1);
      default: return 16'(span);
    endcase
  endfunction

  function automatic in_item_t random_follow();
    in_item_t    it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    it.start_req = 1'b0;
    if ($urandom_range(0, 3) == 0) it.texel = '0;
    return it;
  endfunction

  function automatic in_item_t random_start();
    in_item_t it;
    it = random_follow();
    it.start_req = 1'b1;
    it.side      = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 20))
      0:       it.mode = MODE_UNUSED;
      1, 2, 3, 4, 5, 6: it.mode = MODE_TEX_SHADE;
      7, 8, 9, 10, 11, 12: it.mode = MODE_SKY;
      default: it.mode = MODE_TRANSP;
    endcase
    it.apex_x      = pick_coord(SCR_W);
    it.origin_y    = pick_coord(SCR_H);
    it.color_flags = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Mostly whole triangles with random texels; some cut short, some stray items.
  task automatic queue_random_triangles(input int target);
    int counted;
    int r;
    int len;
    int i;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        len = (r < 75) ? 128 : $urandom_range(1, 127);
        texel_queue.push_back(random_start());
        for (i = 1; i < len; i++) texel_queue.push_back(random_follow());
        counted += len;
      end else begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) texel_queue.push_back(random_follow());
      end
    end
  endtask

  task automatic report(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("ERROR: %s", msg);
  endtask

  task automatic check_write(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (pixel_writes_due.size() == 0) begin
      report($sformatf("write %0d: unexpected transaction %h", results_seen, got));
      return;
    end
    want = pixel_writes_due.pop_front();
    if (got.write_enable !== want.write_enable)
      report($sformatf("write %0d: write_enable %b, want %b", results_seen,
                       got.write_enable, want.write_enable));
    if (got.pixel_address !== want.pixel_address)
      report($sformatf("write %0d: pixel_address %0d, want %0d", results_seen,
                       got.pixel_address, want.pixel_address));
    if (got.pixel_color !== want.pixel_color)
      report($sformatf("write %0d: pixel_color %h, want %h", results_seen,
                       got.pixel_color, want.pixel_color));
    if (got.to_overlay !== want.to_overlay)
      report($sformatf("write %0d: to_overlay %b, want %b", results_seen,
                       got.to_overlay, want.to_overlay));
    if (got.triangle_done !== want.triangle_done)
      report($sformatf("write %0d: triangle_done %b, want %b", results_seen,
                       got.triangle_done, want.triangle_done));
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TARGET_OVERLAY) shd_overlay = val[0];
    else shd_sky = val;
  endtask

  // Returns once every queued texel went in and every write came back.
  task automatic wait_drain();
    // sampled mid-cycle so the driver's pop and its in_valid update agree
    do @(negedge clk); while (texel_queue.size() != 0 || in_valid);
    while (pixel_writes_due.size() != 0) @(posedge clk);
    // dropped texels leave no trace, so give the pipeline time to empty
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        drv_has = blit_texel(in_data, drv_pix);
        if (drv_has) pixel_writes_due.push_back(drv_pix);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (texel_queue.size() > 0) begin
          in_data  <= texel_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_idle(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_write(out_data);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // long hold-off so the pipeline backs up into in_stall
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end else begin
        hold_left = pick_idle(recv_calm);
      end
      out_stall <= (hold_left > 0);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int   phase;
    logic ovl_set[NUM_PHASES];
    logic [7:0] sky_set[NUM_PHASES];
    ovl_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    sky_set = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), 8'h80};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // texels with no triangle active are dropped
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'h00, 8'h00, 8'h00));
    texel_queue.push_back(mk_item(1'b0, 1'b1, MODE_UNUSED, -16'sd1, -16'sd1,
                                  8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // most negative origin, far off screen
    texel_queue.push_back(mk_item(1'b1, 1'b0, MODE_TEX_SHADE, 16'sh8000, 16'sh8000,
                                  8'h00, 8'h00, 8'h00, 8'h00));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'hFF, 8'hFF, 8'hFF));
    // restart into the unused mode at the most positive origin
    texel_queue.push_back(mk_item(1'b1, 1'b1, MODE_UNUSED, 16'sh7FFF, 16'sh7FFF,
                                  8'hFF, 8'hFF, 8'hFF, 8'hFF));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'h12, 8'h34, 8'h56));
    // transparent texels at the screen corner
    texel_queue.push_back(mk_item(1'b1, 1'b1, MODE_TRANSP, 16'sd0, 16'sd0,
                                  8'h80, 8'h00, 8'hFF, 8'hFF));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'h01, 8'h00, 8'h00));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'hFF, 8'h00, 8'h00));
    texel_queue.push_back(mk_item(1'b1, 1'b0, MODE_TRANSP, 16'(SCR_W), 16'(SCR_H - 1),
                                  8'h00, 8'h40, 8'h00, 8'h00));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'h00, 8'h00, 8'h00));
    // left edge and right edge clipping
    texel_queue.push_back(mk_item(1'b1, 1'b0, MODE_SKY, 16'sd0, 16'sd100,
                                  8'h00, 8'h00, 8'h00, 8'hF0));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'h00, 8'h00, 8'h0F));
    texel_queue.push_back(mk_item(1'b1, 1'b1, MODE_SKY, 16'(SCR_W - 1), 16'sd0,
                                  8'h00, 8'h00, 8'h00, 8'h0F));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'h00, 8'h00, 8'h01));
    texel_queue.push_back(mk_item(1'b1, 1'b1, MODE_TEX_SHADE, -16'sd1, -16'sd1,
                                  8'h00, 8'h11, 8'h22, 8'h44));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'h11, 8'h22, 8'h44));
    texel_queue.push_back(mk_item(1'b1, 1'b0, MODE_TEX_SHADE, 16'sd100, 16'sd50,
                                  8'h00, 8'h01, 8'h02, 8'h04));
    texel_queue.push_back(mk_item(1'b0, 1'b0, MODE_TEX_SHADE, 16'sd0, 16'sd0,
                                  8'h00, 8'h80, 8'h40, 8'h20));
    wait_drain();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_cfg(CFG_TARGET_OVERLAY, CFG_W'(ovl_set[phase]));
      write_cfg(CFG_SKY_COLOR, sky_set[phase]);
      queue_random_triangles(PHASE_ITEMS);
      wait_drain();
    end

    if (pixel_writes_due.size() != 0)
      report($sformatf("%0d expected writes never arrived", pixel_writes_due.size()));

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
src/iso_tri_pkg.sv
src/iso_tri_walker.sv
src/iso_tri_compose.sv
src/iso_tri_blitter_top.sv
tb/sv/iso_triangle_blitter_top_tb.sv
